// ===== design/grf_pkg.sv =====
// ----------------------------------------------------------------------------
// grf_pkg: shared types and constants for the Gaussian row smoother
// Item and configuration structs, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package grf_pkg;

  localparam int FIELD_BITS      = 16;
  localparam int COEFF_BITS      = 16;
  localparam int RADIUS_BITS     = 3;
  localparam int SIDE_COUNT      = 6;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int ROUND_SHIFT     = 15;
  localparam int MAX_RADIUS_DEF  = 6;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);
  localparam logic [COEFF_BITS-1:0]  CENTER_RESET = COEFF_BITS'(32768);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RADIUS,
    REG_CENTER,
    REG_SIDE_ONE,
    REG_SIDE_TWO,
    REG_SIDE_THREE,
    REG_SIDE_FOUR,
    REG_SIDE_FIVE,
    REG_SIDE_SIX
  } grf_reg_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] sample;
    logic                         row_end;
  } grf_in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] smoothed;
    logic                         last;
  } grf_out_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0]                radius;
    logic [COEFF_BITS-1:0]                 center;
    logic [SIDE_COUNT-1:0][COEFF_BITS-1:0] side;
  } grf_cfg_t;

endpackage

// ===== design/grf_cfg.sv =====
// ----------------------------------------------------------------------------
// grf_cfg: configuration registers
// Holds the radius and kernel weights and presents the radius clamped to the
// supported range.
// ----------------------------------------------------------------------------
module grf_cfg #(
  parameter int MAX_RADIUS = grf_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [grf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [grf_pkg::COEFF_BITS-1:0]      cfg_data,
  output grf_pkg::grf_cfg_t                   cfg
);
  import grf_pkg::*;

  logic [RADIUS_BITS-1:0]                radius;
  logic [COEFF_BITS-1:0]                 center;
  logic [SIDE_COUNT-1:0][COEFF_BITS-1:0] side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      center <= CENTER_RESET;
      side   <= '0;
    end else if (cfg_valid) begin
      unique case (grf_reg_t'(cfg_index))
        REG_RADIUS:     radius  <= cfg_data[RADIUS_BITS-1:0];
        REG_CENTER:     center  <= cfg_data;
        REG_SIDE_ONE:   side[0] <= cfg_data;
        REG_SIDE_TWO:   side[1] <= cfg_data;
        REG_SIDE_THREE: side[2] <= cfg_data;
        REG_SIDE_FOUR:  side[3] <= cfg_data;
        REG_SIDE_FIVE:  side[4] <= cfg_data;
        REG_SIDE_SIX:   side[5] <= cfg_data;
      endcase
    end
  end

  always_comb begin
    cfg.center = center;
    cfg.side   = side;
    if (radius == '0) begin
      cfg.radius = RADIUS_BITS'(1);
    end else if (radius > RADIUS_BITS'(MAX_RADIUS)) begin
      cfg.radius = RADIUS_BITS'(MAX_RADIUS);
    end else begin
      cfg.radius = radius;
    end
  end

endmodule

// ===== design/grf_window.sv =====
// ----------------------------------------------------------------------------
// grf_window: delay line and window capture
// Shifts accepted samples into the tap line, counts the samples of the row
// and captures a full window whenever the row has filled it.
// ----------------------------------------------------------------------------
module grf_window #(
  parameter int MAX_RADIUS  = grf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = grf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   feed_valid,
  output logic                                   feed_stall,
  input  grf_pkg::grf_in_t                       feed,
  input  logic [grf_pkg::RADIUS_BITS-1:0]        radius,
  output logic                                   win_valid,
  output logic                                   win_last,
  output logic [2*MAX_RADIUS:0][SAMPLE_BITS-1:0] win,
  input  logic                                   win_ready
);
  import grf_pkg::*;

  localparam int TAP_DEPTH = 2 * MAX_RADIUS;
  localparam int FILL_W    = $clog2(TAP_DEPTH + 1);

  logic [SAMPLE_BITS-1:0] taps [TAP_DEPTH];
  logic [FILL_W-1:0]      fill_count;
  logic [FILL_W-1:0]      twice_r;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   hold_free;
  logic                   accept;
  logic                   produce;

  assign sample_in  = feed.sample[SAMPLE_BITS-1:0];
  assign hold_free  = !win_valid || win_ready;
  assign feed_stall = !hold_free;
  assign accept     = feed_valid && hold_free;
  assign twice_r    = FILL_W'({radius, 1'b0});
  assign produce    = fill_count >= twice_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid  <= 1'b0;
      fill_count <= '0;
      for (int i = 0; i < TAP_DEPTH; i++) begin
        taps[i] <= '0;
      end
    end else begin
      if (hold_free) begin
        win_valid <= accept && produce;
      end
      if (accept) begin
        taps[0] <= sample_in;
        for (int i = 1; i < TAP_DEPTH; i++) begin
          taps[i] <= taps[i-1];
        end
        if (feed.row_end) begin
          fill_count <= '0;
        end else if (fill_count < FILL_W'(TAP_DEPTH)) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_last <= feed.row_end;
      win[0]   <= sample_in;
      for (int i = 0; i < TAP_DEPTH; i++) begin
        win[i+1] <= taps[i];
      end
    end
  end

endmodule

// ===== design/grf_mac.sv =====
// ----------------------------------------------------------------------------
// grf_mac: symmetric kernel multiply, sum, round and saturate
// Pre-adds mirrored taps, multiplies by the weights, sums the products and
// rounds half up at Q1.15 with saturation into the result register.
// ----------------------------------------------------------------------------
module grf_mac #(
  parameter int MAX_RADIUS  = grf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = grf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  grf_pkg::grf_cfg_t                      cfg,
  input  logic                                   win_valid,
  input  logic                                   win_last,
  input  logic [2*MAX_RADIUS:0][SAMPLE_BITS-1:0] win,
  output logic                                   win_ready,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output grf_pkg::grf_out_t                      result
);
  import grf_pkg::*;

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PC_W   = COEFF_BITS + 1 + SAMPLE_BITS;
  localparam int PS_W   = COEFF_BITS + 1 + PAIR_W;
  localparam int SUM_W  = PS_W + $clog2(MAX_RADIUS + 1) + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [SAMPLE_BITS-1:0] centre;
  logic signed [PAIR_W-1:0]      pair [MAX_RADIUS];

  logic                          p_valid;
  logic                          p_last;
  logic signed [PC_W-1:0]        p_centre;
  logic signed [PS_W-1:0]        p_side [MAX_RADIUS];

  logic                          s_valid;
  logic                          s_last;
  logic signed [SUM_W-1:0]       s_sum;
  logic signed [SUM_W-1:0]       sum_next;

  logic signed [SUM_W-1:0]       rounded;
  logic signed [SAMPLE_BITS-1:0] clipped;

  logic                          o_free;
  logic                          s_free;
  logic                          p_free;

  assign o_free    = !result_valid || !result_stall;
  assign s_free    = !s_valid || o_free;
  assign p_free    = !p_valid || s_free;
  assign win_ready = p_free;

  always_comb begin
    centre = '0;
    for (int d = 0; d < MAX_RADIUS; d++) begin
      pair[d] = '0;
    end
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      if (cfg.radius == RADIUS_BITS'(k)) begin
        centre = $signed(win[k]);
        for (int d = 1; d <= k; d++) begin
          pair[d-1] = PAIR_W'($signed(win[k-d])) + PAIR_W'($signed(win[k+d]));
        end
      end
    end
  end

  always_comb begin
    sum_next = SUM_W'(p_centre);
    for (int d = 0; d < MAX_RADIUS; d++) begin
      sum_next = sum_next + SUM_W'(p_side[d]);
    end
  end

  always_comb begin
    rounded = (s_sum + ROUND_HALF) >>> ROUND_SHIFT;
    if (rounded > SAT_HI) begin
      clipped = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rounded < SAT_LO) begin
      clipped = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      clipped = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      s_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (p_free) begin
        p_valid <= win_valid;
      end
      if (s_free) begin
        s_valid <= p_valid;
      end
      if (o_free) begin
        result_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      p_last   <= win_last;
      p_centre <= PC_W'($signed({1'b0, cfg.center})) * PC_W'(centre);
      for (int d = 0; d < MAX_RADIUS; d++) begin
        p_side[d] <= PS_W'($signed({1'b0, cfg.side[d]})) * PS_W'(pair[d]);
      end
    end
    if (s_free) begin
      s_last <= p_last;
      s_sum  <= sum_next;
    end
    if (o_free) begin
      result.last     <= s_last;
      result.smoothed <= FIELD_BITS'(clipped);
    end
  end

endmodule

// ===== design/gaussian_row_fir.sv =====
// ----------------------------------------------------------------------------
// gaussian_row_fir: streaming 1-D symmetric Gaussian smoother
// Filters padded rows of signed samples with a mirrored Q1.15 kernel.
// ----------------------------------------------------------------------------
// Samples enter on the feed channel (feed_valid, feed_stall, feed) and are
// taken at any edge where feed_valid is high and feed_stall is low. A row of
// n + 2*radius padded samples, its final sample flagged by row_end, yields n
// results on the result channel; the result made by the row_end sample has
// last set. Short rows yield nothing.
// One sample is taken in every cycle in which feed_stall is low. The sample
// that completes a window passes through window capture, pre-add and multiply,
// product sum, then round and saturate into the result register.
// When result_stall is held, each pipeline stage keeps its item and the
// feed channel stalls only once every stage holds an item.
// The cfg channel writes the radius (index 0), the centre weight (index 1)
// and the side weights (indices 2 to 7); it is always ready, but it must be
// written only while no item is in flight, which the block does not enforce.
// A synchronous reset empties the pipeline, clears the delay line and the
// row count and restores radius one with a unit centre weight.
// ----------------------------------------------------------------------------
module gaussian_row_fir #(
  parameter int MAX_RADIUS  = grf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = grf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               feed_valid,
  output logic                               feed_stall,
  input  grf_pkg::grf_in_t                   feed,
  output logic                               result_valid,
  input  logic                               result_stall,
  output grf_pkg::grf_out_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [grf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [grf_pkg::COEFF_BITS-1:0]     cfg_data
);
  import grf_pkg::*;

  grf_cfg_t                              cfg;
  logic                                  win_valid;
  logic                                  win_last;
  logic                                  win_ready;
  logic [2*MAX_RADIUS:0][SAMPLE_BITS-1:0] win;

  grf_cfg #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  grf_window #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (feed_valid),
    .feed_stall (feed_stall),
    .feed       (feed),
    .radius     (cfg.radius),
    .win_valid  (win_valid),
    .win_last   (win_last),
    .win        (win),
    .win_ready  (win_ready)
  );

  grf_mac #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .win_valid    (win_valid),
    .win_last     (win_last),
    .win          (win),
    .win_ready    (win_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== dv/tb_gaussian_row_fir.sv =====
// ----------------------------------------------------------------------------
// tb_gaussian_row_fir: self-checking bench for the Gaussian row smoother
// Streams padded rows under many kernel settings. Both channels have random
// idle and stall cycles, and one long result hold-off backs up the feed.
// Each result is compared with a cycle-free model of the filter kept here.
// ----------------------------------------------------------------------------
module tb_gaussian_row_fir;
  timeunit 1ns;
  timeprecision 1ps;

  import grf_pkg::*;

  localparam int TAP_DEPTH     = 2 * MAX_RADIUS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 200;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam int SQUEEZE_PHASE = 6;
  localparam int SQUEEZE_ITEMS = 300;

  typedef enum int {W_BELL, W_ANY, W_IN_RANGE, W_ALL_MAX, W_ALL_ONE, W_ALL_ZERO} weight_mode_t;
  typedef enum int {S_ANY, S_EDGE, S_FLAT, S_SMALL} sample_style_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      feed_valid = 1'b0;
  logic                      feed_stall;
  grf_in_t                   feed = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  grf_out_t                  result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COEFF_BITS-1:0]     cfg_data = '0;

  logic [RADIUS_BITS-1:0]       kern_radius;
  logic [COEFF_BITS-1:0]        kern_weight [0:SIDE_COUNT];
  logic signed [FIELD_BITS-1:0] tap_hist [0:TAP_DEPTH-1];
  int                           row_fill;
  grf_out_t                     smoothed_due [$];
  grf_in_t                      pending [$];
  logic [COEFF_BITS-1:0]        kernel_words [8];

  bit feed_idle_on = 1'b0;
  bit result_idle_on = 1'b0;
  bit squeeze_armed = 1'b0;
  bit hold_off = 1'b0;
  int idle_left = 0;
  int stall_left = 0;
  int fail_count = 0;
  int results_checked = 0;
  int samples_queued = 0;
  int samples_taken = 0;
  int rows_queued = 0;
  int kernels_loaded = 0;
  int feed_backed_up = 0;
  int cycle_count = 0;

  gaussian_row_fir dut (
    .clk          (clk),
    .rst          (rst),
    .feed_valid   (feed_valid),
    .feed_stall   (feed_stall),
    .feed         (feed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int active_radius(logic [RADIUS_BITS-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_RADIUS_DEF) return MAX_RADIUS_DEF;
    return int'(setting);
  endfunction

  function automatic void smooth_sample(grf_in_t item);
    logic signed [FIELD_BITS-1:0] window [0:TAP_DEPTH];
    int       r;
    longint   acc;
    longint   rounded;
    grf_out_t res;
    r = active_radius(kern_radius);
    window[0] = item.sample;
    for (int i = 0; i < TAP_DEPTH; i++) window[i + 1] = tap_hist[i];
    if (row_fill >= 2 * r) begin
      acc = longint'(kern_weight[0]) * longint'(window[r]);
      for (int d = 1; d <= r; d++) begin
        acc += longint'(kern_weight[d]) * (longint'(window[r - d]) + longint'(window[r + d]));
      end
      rounded = (acc + 64'sd16384) >>> ROUND_SHIFT;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      res.smoothed = rounded[FIELD_BITS-1:0];
      res.last = item.row_end;
      smoothed_due.push_back(res);
    end
    for (int i = TAP_DEPTH - 1; i > 0; i--) tap_hist[i] = tap_hist[i - 1];
    tap_hist[0] = item.sample;
    if (item.row_end) row_fill = 0;
    else if (row_fill < TAP_DEPTH) row_fill++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      feed_valid <= 1'b0;
      feed <= '0;
      idle_left = 0;
      row_fill = 0;
      foreach (tap_hist[i]) tap_hist[i] = '0;
    end else begin
      if (feed_valid && !feed_stall) begin
        smooth_sample(feed);
        samples_taken++;
      end
      if (feed_valid && feed_stall) feed_backed_up++;
      if (!feed_valid || !feed_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          feed_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          feed <= pending.pop_front();
          feed_valid <= 1'b1;
          idle_left = feed_idle_on ? pick_idle() : 0;
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      kern_radius <= RADIUS_RESET;
      kern_weight[0] <= CENTER_RESET;
      for (int d = 1; d <= SIDE_COUNT; d++) kern_weight[d] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (grf_reg_t'(cfg_index) == REG_RADIUS) kern_radius <= cfg_data[RADIUS_BITS-1:0];
      else kern_weight[int'(cfg_index) - int'(REG_CENTER)] <= cfg_data;
    end
  end

  always @(posedge clk) begin
    grf_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (smoothed_due.size() == 0) begin
          $error("smoothed: expected no item, got %0d (last %0b)", result.smoothed, result.last);
          fail_count++;
        end else begin
          want = smoothed_due.pop_front();
          results_checked++;
          if (result.smoothed !== want.smoothed) begin
            $error("smoothed: expected %0d, got %0d", want.smoothed, result.smoothed);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result.last);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (result_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_idle();
      result_stall <= hold_off || (stall_left > 0);
    end
  end

  initial begin
    wait (squeeze_armed);
    @(posedge clk);
    hold_off <= 1'b1;
    for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void push_sample(logic signed [FIELD_BITS-1:0] value, logic closes_row);
    grf_in_t item;
    item.sample = value;
    item.row_end = closes_row;
    pending.push_back(item);
    samples_queued++;
    if (closes_row) rows_queued++;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] pick_sample(sample_style_t style,
                                                              logic signed [FIELD_BITS-1:0] level);
    int offset;
    case (style)
      S_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          4: return 16'sh0001;
          default: return 16'($urandom());
        endcase
      end
      S_FLAT: return level;
      S_SMALL: begin
        offset = $urandom_range(0, 200);
        return 16'(offset - 100);
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void random_kernel(int phase);
    int           r;
    weight_mode_t mode;
    r = $urandom_range(0, 7);
    mode = ($urandom_range(0, 9) < 8) ? weight_mode_t'($urandom_range(0, 2)) : W_ALL_MAX;
    if (phase == 0) begin
      r = 7;
      mode = W_ALL_ONE;
    end else if (phase == 1) begin
      r = MAX_RADIUS_DEF;
      mode = W_ALL_ZERO;
    end
    kernel_words[REG_RADIUS] = 16'(r);
    if ($urandom_range(0, 1) != 0) kernel_words[REG_RADIUS][15:RADIUS_BITS] = 13'($urandom());
    for (int i = 0; i <= SIDE_COUNT; i++) begin
      case (mode)
        W_BELL: kernel_words[int'(REG_CENTER) + i] =
            16'((i == 0) ? $urandom_range(4096, 32768) : $urandom_range(0, 32768 >> i));
        W_ANY: kernel_words[int'(REG_CENTER) + i] = 16'($urandom());
        W_IN_RANGE: kernel_words[int'(REG_CENTER) + i] = 16'($urandom_range(0, 32768));
        W_ALL_MAX: kernel_words[int'(REG_CENTER) + i] = 16'hFFFF;
        W_ALL_ONE: kernel_words[int'(REG_CENTER) + i] = 16'h8000;
        default: kernel_words[int'(REG_CENTER) + i] = 16'h0000;
      endcase
    end
  endfunction

  function automatic void queue_rows(int count, bit leave_open);
    int                           r;
    int                           len;
    int                           roll;
    int                           made;
    bit                           noisy;
    sample_style_t                style;
    logic signed [FIELD_BITS-1:0] level;
    r = active_radius(kernel_words[REG_RADIUS][RADIUS_BITS-1:0]);
    made = 0;
    while (made < count) begin
      style = sample_style_t'($urandom_range(0, 3));
      level = 16'($urandom());
      roll = $urandom_range(0, 9);
      noisy = (roll == 1);
      if (roll == 0) len = $urandom_range(1, 2 * r);
      else if (noisy) len = 12;
      else if (roll == 2) len = 2 * r + $urandom_range(20, 50);
      else len = 2 * r + $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        push_sample(pick_sample(style, level),
                    noisy ? ($urandom_range(0, 7) == 0) : (k == len - 1));
      end
      made += len;
    end
    if (leave_open) begin
      len = $urandom_range(1, 2 * r);
      for (int k = 0; k < len; k++) push_sample(16'($urandom()), 1'b0);
    end
  endfunction

  task automatic load_kernel();
    grf_reg_t idx;
    idx = REG_RADIUS;
    @(posedge clk);
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= kernel_words[idx];
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end while (idx != REG_RADIUS);
    cfg_valid <= 1'b0;
    kernels_loaded++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (samples_taken != samples_queued || smoothed_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shFFFF, 1'b0);
    push_sample(16'sh0001, 1'b0);
    push_sample(16'sh3039, 1'b1);
    push_sample(16'sh0064, 1'b0);
    push_sample(16'sh00C8, 1'b1);
    push_sample(16'shFFFB, 1'b1);
    wait_drained();

    kernel_words[REG_RADIUS] = 16'hFFF8;
    for (int i = 0; i <= SIDE_COUNT; i++) kernel_words[int'(REG_CENTER) + i] = 16'hFFFF;
    load_kernel();
    for (int k = 0; k < 3; k++) push_sample(16'sh7FFF, k == 2);
    for (int k = 0; k < 3; k++) push_sample(16'sh8000, k == 2);
    wait_drained();

    kernel_words[REG_RADIUS] = 16'd2;
    kernel_words[REG_CENTER] = 16'd12000;
    kernel_words[REG_SIDE_ONE] = 16'd8000;
    kernel_words[REG_SIDE_TWO] = 16'd2384;
    for (int i = 3; i <= SIDE_COUNT; i++) kernel_words[int'(REG_CENTER) + i] = 16'($urandom());
    load_kernel();
    push_sample(16'sh1000, 1'b0);
    push_sample(16'shE000, 1'b0);
    push_sample(16'sh2345, 1'b0);
    wait_drained();

    kernel_words[REG_RADIUS] = 16'd1;
    load_kernel();
    push_sample(16'sh7000, 1'b0);
    push_sample(16'sh9000, 1'b0);
    push_sample(16'sh0100, 1'b1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_kernel(p);
      load_kernel();
      feed_idle_on = ($urandom_range(0, 3) != 0);
      result_idle_on = ($urandom_range(0, 3) != 0);
      if (p == SQUEEZE_PHASE) begin
        feed_idle_on = 1'b0;
        result_idle_on = 1'b0;
        queue_rows(SQUEEZE_ITEMS, 1'b0);
        squeeze_armed = 1'b1;
      end else begin
        queue_rows(PHASE_ITEMS, $urandom_range(0, 3) == 0);
      end
      wait_drained();
    end

    $display("Streamed %0d samples in %0d closed rows under %0d kernel settings.",
             samples_taken, rows_queued, kernels_loaded);
    $display("Checked %0d results; the feed was held back on %0d cycles.",
             results_checked, feed_backed_up);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/grf_pkg.sv
design/grf_cfg.sv
design/grf_window.sv
design/grf_mac.sv
design/gaussian_row_fir.sv
dv/tb_gaussian_row_fir.sv
